[rtl/core/sdf_pkg.sv]
// sdf_pkg: shared constants, command codes and transaction types for the
// set difference filter. No dependencies.
package sdf_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int KEPT_W      = 16;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_TEST  = 2'd2;

  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FULL = 1'b1;

  typedef struct packed {
    logic [1:0]                   command;
    logic signed [DATA_WIDTH-1:0] value;
    logic                         last_item;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] out_value;
    logic                         keep;
    logic [KEPT_W-1:0]            kept_count;
    logic                         status;
    logic                         out_last;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic clear;
    logic append;
    logic test;
    logic drop;
  } dp_cmd_t;

  typedef struct packed {
    logic table_full;
  } dp_stat_t;

endpackage

[rtl/core/sdf_ctrl.sv]
// sdf_ctrl: handshake state machine and command decode for the filter.
// Depends on sdf_pkg.
module sdf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_command,
  output logic             out_valid,
  input  logic             out_stall,
  output sdf_pkg::dp_cmd_t dp_cmd,
  input  sdf_pkg::dp_stat_t dp_stat
);
  import sdf_pkg::*;

  localparam logic ST_EMPTY = 1'b0;
  localparam logic ST_FULL  = 1'b1;

  logic state_r;
  logic state_nxt;
  logic take;

  assign in_stall  = (state_r == ST_FULL) && out_stall;
  assign out_valid = (state_r == ST_FULL);
  assign take      = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_EMPTY: begin
        if (take) state_nxt = ST_FULL;
      end
      ST_FULL: begin
        if (!out_stall && !take) state_nxt = ST_EMPTY;
      end
      default: state_nxt = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    dp_cmd         = '0;
    dp_cmd.capture = take;
    if (take) begin
      case (in_command)
        CMD_CLEAR: dp_cmd.clear = 1'b1;
        CMD_LOAD: begin
          dp_cmd.append = !dp_stat.table_full;
          dp_cmd.drop   = dp_stat.table_full;
        end
        CMD_TEST:  dp_cmd.test = 1'b1;
        default:   ;
      endcase
    end
  end

endmodule

[rtl/core/sdf_dp.sv]
// sdf_dp: exclusion table, entry and kept counters, parallel match and
// output register. Depends on sdf_pkg.
module sdf_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  sdf_pkg::in_item_t  in_data,
  input  sdf_pkg::dp_cmd_t   dp_cmd,
  output sdf_pkg::dp_stat_t  dp_stat,
  output sdf_pkg::out_item_t out_data
);
  import sdf_pkg::*;

  logic [DATA_WIDTH-1:0] tbl_r [TABLE_DEPTH];
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic [KEPT_W-1:0]     kept_r;
  logic [KEPT_W-1:0]     kept_nxt;
  logic                  hit;
  logic                  keep;
  out_item_t             res_r;

  assign dp_stat.table_full = (count_r == CNT_W'(TABLE_DEPTH));

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if ((CNT_W'(i) < count_r) && (tbl_r[i] == in_data.value)) hit = 1'b1;
    end
  end

  assign keep = dp_cmd.test && !hit;

  always_comb begin
    count_nxt = count_r;
    kept_nxt  = kept_r;
    if (dp_cmd.clear) begin
      count_nxt = '0;
      kept_nxt  = '0;
    end else begin
      if (dp_cmd.append) count_nxt = count_r + CNT_W'(1);
      if (keep && (kept_r != {KEPT_W{1'b1}})) kept_nxt = kept_r + KEPT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      kept_r  <= '0;
    end else if (dp_cmd.capture) begin
      count_r <= count_nxt;
      kept_r  <= kept_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.append) tbl_r[count_r[IDX_W-1:0]] <= in_data.value;
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      res_r.out_value  <= in_data.value;
      res_r.keep       <= keep;
      res_r.kept_count <= kept_nxt;
      res_r.status     <= dp_cmd.drop ? STAT_FULL : STAT_OK;
      res_r.out_last   <= in_data.last_item;
    end
  end

  assign out_data = res_r;

endmodule

[rtl/core/set_difference_filter.sv]
// set_difference_filter: top level joining the controller and datapath.
// Depends on sdf_pkg, sdf_ctrl, sdf_dp.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one command per
//   transaction: clear, load an exclusion value, or test a value.
//   Output channel out_valid/out_stall/out_data returns exactly one result
//   transaction per accepted command, in order.
//   A command accepted at one edge is shown on out_data after that edge.
//   Throughput is one transaction per cycle while out_stall is low; the
//   test compares against all table entries at once, so no loop stalls it.
//   The single output register is the only buffer: while it holds a result
//   and out_stall is high, in_stall is high; as soon as the result is taken
//   a new command can be accepted in that same cycle.
//   Reset clears the entry count, the kept count and the output valid; the
//   table contents are not cleared and are only read below the entry count.
//   A load into a full table is dropped and reported with status 1.
module set_difference_filter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sdf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sdf_pkg::out_item_t out_data
);
  import sdf_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  sdf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_data.command),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .dp_cmd     (dp_cmd),
    .dp_stat    (dp_stat)
  );

  sdf_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .dp_cmd   (dp_cmd),
    .dp_stat  (dp_stat),
    .out_data (out_data)
  );

endmodule

[rtl/core/sdf_checker.sv]
// sdf_checker: port-level assertions for set_difference_filter, with bind.
// Depends on sdf_pkg.
module sdf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input sdf_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input sdf_pkg::out_item_t out_data
);
  import sdf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled output transaction changed");

  a_echo: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=>
      (out_valid && (out_data.out_value == $past(in_data.value))
       && (out_data.out_last == $past(in_data.last_item))))
    else $error("accepted transaction not echoed on next cycle");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_data.command == CMD_CLEAR)) |=>
      ((out_data.kept_count == '0) && !out_data.keep && !out_data.status))
    else $error("clear did not zero the kept count");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with no pending output");

endmodule

bind set_difference_filter sdf_checker u_sdf_checker (.*);

[sim/testbench.sv]
// testbench: self-checking bench for set_difference_filter, predicting every
// result transaction and comparing field by field. Depends on sdf_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
  import sdf_pkg::*;

  localparam logic [1:0]        CMD_UNUSED = 2'd3;
  localparam logic [KEPT_W-1:0] KEPT_MAX   = '1;
  localparam int                STALL_PCT  = 38;
  localparam int                WDOG_LIMIT = 2000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  set_difference_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state
  logic [DATA_WIDTH-1:0] excl_tbl [TABLE_DEPTH];
  int                    excl_count = 0;
  logic [KEPT_W-1:0]     kept_total = '0;

  in_item_t  cmd_queue[$];
  out_item_t pending_results[$];
  int        n_accepted = 0;
  int        errs = 0;
  int        idle_cycles = 0;
  logic      calm;

  // no idling on either side in this window
  assign calm = (n_accepted >= 400) && (n_accepted < 800);

  function automatic out_item_t predict_filter_result(in_item_t it);
    out_item_t r;
    logic      hit;
    r.out_value = it.value;
    r.keep      = 1'b0;
    r.status    = STAT_OK;
    r.out_last  = it.last_item;
    case (it.command)
      CMD_CLEAR: begin
        excl_count = 0;
        kept_total = '0;
      end
      CMD_LOAD: begin
        if (excl_count < TABLE_DEPTH) begin
          excl_tbl[excl_count] = it.value;
          excl_count++;
        end else begin
          r.status = STAT_FULL;
        end
      end
      CMD_TEST: begin
        hit = 1'b0;
        for (int i = 0; i < excl_count; i++)
          if (excl_tbl[i] == it.value) hit = 1'b1;
        if (!hit) begin
          r.keep = 1'b1;
          if (kept_total != KEPT_MAX) kept_total++;
        end
      end
      default: ;
    endcase
    r.kept_count = kept_total;
    return r;
  endfunction

  task automatic push(logic [1:0] cmd, logic [DATA_WIDTH-1:0] v, logic last);
    in_item_t it;
    it.command   = cmd;
    it.value     = v;
    it.last_item = last;
    cmd_queue.push_back(it);
  endtask

  function automatic logic [DATA_WIDTH-1:0] rand_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return {1'b1, {(DATA_WIDTH-1){1'b0}}};
      3:       return {1'b0, {(DATA_WIDTH-1){1'b1}}};
      default: return $urandom;
    endcase
  endfunction

  task automatic check_field(string name, logic [DATA_WIDTH-1:0] e, logic [DATA_WIDTH-1:0] g);
    if (e !== g) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, e, g);
      errs++;
    end
  endtask

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        pending_results.push_back(predict_filter_result(in_data));
        n_accepted++;
      end
      if (cmd_queue.size() != 0 && (calm || $urandom_range(99) >= STALL_PCT)) begin
        in_valid <= 1'b1;
        in_data  <= cmd_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result transaction, actual %h", $time, out_data);
          errs++;
        end else begin
          exp_r = pending_results.pop_front();
          check_field("out_value", exp_r.out_value, out_data.out_value);
          check_field("keep", DATA_WIDTH'(exp_r.keep), DATA_WIDTH'(out_data.keep));
          check_field("kept_count", DATA_WIDTH'(exp_r.kept_count),
                      DATA_WIDTH'(out_data.kept_count));
          check_field("status", DATA_WIDTH'(exp_r.status), DATA_WIDTH'(out_data.status));
          check_field("out_last", DATA_WIDTH'(exp_r.out_last),
                      DATA_WIDTH'(out_data.out_last));
        end
      end
      out_stall <= !calm && ($urandom_range(99) < STALL_PCT);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cmd_queue.size() == 0 && !in_valid && pending_results.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and end of run
  initial begin
    logic [DATA_WIDTH-1:0] loaded[$];
    logic [DATA_WIDTH-1:0] v;
    int                    n_rand;
    int                    n_load;
    int                    n_test;

    // directed
    push(CMD_TEST, '0, 1'b0);
    push(CMD_TEST, 32'h7FFF_FFFF, 1'b1);
    push(CMD_LOAD, 32'h8000_0000, 1'b0);
    push(CMD_LOAD, 32'h7FFF_FFFF, 1'b1);
    push(CMD_LOAD, '0, 1'b0);
    push(CMD_LOAD, '1, 1'b0);
    push(CMD_TEST, 32'h8000_0000, 1'b0);
    push(CMD_TEST, 32'h8000_0001, 1'b0);
    push(CMD_TEST, '0, 1'b1);
    push(CMD_UNUSED, '1, 1'b1);
    for (int i = 0; i < TABLE_DEPTH - 4; i++)
      push(CMD_LOAD, $urandom, i[0]);
    push(CMD_LOAD, 32'd5, 1'b1);
    push(CMD_TEST, 32'd5, 1'b0);
    push(CMD_CLEAR, '1, 1'b1);
    push(CMD_TEST, 32'h8000_0000, 1'b1);

    // random sequences: an optional clear, loads, then a test stream; some single random commands
    n_rand = 0;
    while (n_rand < 1600) begin
      if ($urandom_range(99) < 8) begin
        push(2'($urandom_range(3)), rand_value(), 1'($urandom_range(1)));
        n_rand++;
      end else begin
        if ($urandom_range(9) < 7) begin
          push(CMD_CLEAR, rand_value(), 1'($urandom_range(1)));
          loaded.delete();
          n_rand++;
        end
        n_load = $urandom_range(18);
        for (int i = 0; i < n_load; i++) begin
          v = rand_value();
          push(CMD_LOAD, v, 1'($urandom_range(1)));
          loaded.push_back(v);
        end
        n_test = $urandom_range(1, 24);
        for (int i = 0; i < n_test; i++) begin
          if (loaded.size() != 0 && $urandom_range(1))
            v = loaded[$urandom_range(loaded.size() - 1)];
          else
            v = rand_value();
          push(CMD_TEST, v, i == n_test - 1);
        end
        n_rand += n_load + n_test;
      end
    end

    // load after clear, then match and miss, then clear and test again
    push(CMD_CLEAR, '0, 1'b0);
    push(CMD_LOAD, 32'h1234_5678, 1'b0);
    push(CMD_TEST, 32'h1234_5678, 1'b0);
    push(CMD_TEST, 32'h1234_5679, 1'b1);
    push(CMD_CLEAR, '0, 1'b1);
    push(CMD_TEST, 32'h1234_5678, 1'b1);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_queue.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
    if (errs == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
